[design/alpf_pkg.sv]
// Shared constants and types for the addressable LED pulse encoder.
`timescale 1ns / 1ps
package alpf_pkg;

   localparam int BYTES_PER_PIXEL_DEF = 3;
   localparam int BITS_PER_BYTE       = 8;
   localparam int TIME_W              = 16;
   localparam int LATCH_W             = 20;
   localparam int CSR_IDX_W           = 3;
   localparam int CSR_DATA_W          = 20;
   localparam int RSP_DATA_W          = 40;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [TIME_W-1:0]  ZERO_HIGH_RST = 16'd350;
   localparam logic [TIME_W-1:0]  ZERO_LOW_RST  = 16'd900;
   localparam logic [TIME_W-1:0]  ONE_HIGH_RST  = 16'd900;
   localparam logic [TIME_W-1:0]  ONE_LOW_RST   = 16'd350;
   localparam logic [LATCH_W-1:0] LATCH_RST     = 20'd50000;

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH     = 3'd4;

   typedef struct packed {
      logic has_pixel;
      logic has_latch;
   } job_flags_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_BITS,
      BK_LATCH
   } back_state_type;

endpackage

[design/alpf_front.sv]
// Front end: gathers colour bytes into pixels and queues pixel and latch jobs.
`timescale 1ns / 1ps
module alpf_front #(
   parameter int BYTES_PER_PIXEL = alpf_pkg::BYTES_PER_PIXEL_DEF,
   parameter int PIX_BITS        = BYTES_PER_PIXEL * alpf_pkg::BITS_PER_BYTE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [alpf_pkg::BITS_PER_BYTE-1:0] req_tdata,
   input  logic                          req_tlast,
   input  logic                          q_full,
   output logic                          push,
   output logic [PIX_BITS-1:0]           push_pixel,
   output alpf_pkg::job_flags_type       push_flags
);
   import alpf_pkg::*;

   localparam int CNT_W     = $clog2(BYTES_PER_PIXEL);
   localparam int HOLD_BITS = PIX_BITS - BITS_PER_BYTE;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [HOLD_BITS-1:0] hold_ff, hold_in;
   logic                 accept;
   logic                 complete;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign complete   = (count_ff == CNT_W'(BYTES_PER_PIXEL - 1));

   always_comb begin
      count_in = count_ff;
      hold_in  = hold_ff;
      if (accept) begin
         hold_in = {hold_ff[HOLD_BITS-BITS_PER_BYTE-1:0], req_tdata};
         if (complete || req_tlast) begin
            count_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign push                 = accept && (complete || req_tlast);
   assign push_pixel           = {hold_ff, req_tdata};
   assign push_flags.has_pixel = complete;
   assign push_flags.has_latch = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

[design/alpf_queue.sv]
// Short job queue between the front end and the pulse sequencer.
`timescale 1ns / 1ps
module alpf_queue #(
   parameter int PIX_BITS = alpf_pkg::BYTES_PER_PIXEL_DEF * alpf_pkg::BITS_PER_BYTE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [PIX_BITS-1:0]     push_pixel,
   input  alpf_pkg::job_flags_type push_flags,
   input  logic                    pop,
   output logic                    full,
   output logic                    empty,
   output logic [PIX_BITS-1:0]     head_pixel,
   output alpf_pkg::job_flags_type head_flags
);
   import alpf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [PIX_BITS-1:0] pixel_ff [QUEUE_DEPTH];
   job_flags_type       flags_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (cnt_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_pixel = pixel_ff[rd_ptr_ff];
   assign head_flags = flags_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         pixel_ff[wr_ptr_ff] <= push_pixel;
         flags_ff[wr_ptr_ff] <= push_flags;
      end
   end

endmodule

[design/alpf_back.sv]
// Pulse sequencer: timing registers and one descriptor beat per pixel bit, then a latch beat if the job has one.
`timescale 1ns / 1ps
module alpf_back #(
   parameter int PIX_BITS = alpf_pkg::BYTES_PER_PIXEL_DEF * alpf_pkg::BITS_PER_BYTE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [alpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [alpf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              empty,
   input  logic [PIX_BITS-1:0]               head_pixel,
   input  alpf_pkg::job_flags_type           head_flags,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [alpf_pkg::TIME_W-1:0]       rsp_high,
   output logic [alpf_pkg::LATCH_W-1:0]      rsp_low,
   output logic                              rsp_bit,
   output logic                              rsp_latch,
   output logic                              rsp_last
);
   import alpf_pkg::*;

   localparam int LEFT_W = $clog2(PIX_BITS);

   logic [TIME_W-1:0]   zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [LATCH_W-1:0]  latch_ff;

   back_state_type      state_ff, state_in;
   logic [PIX_BITS-1:0] shift_ff, shift_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic                latch_pend_ff, latch_pend_in;
   logic                valid_ff, valid_in;
   logic [TIME_W-1:0]   high_ff, high_in;
   logic [LATCH_W-1:0]  low_ff, low_in;
   logic                bit_ff, bit_in;
   logic                islatch_ff, islatch_in;
   logic                last_ff, last_in;
   logic                slot_free;
   logic                cur_bit;

   assign slot_free = !valid_ff || rsp_tready;
   assign cur_bit   = shift_ff[PIX_BITS-1];

   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      left_in       = left_ff;
      latch_pend_in = latch_pend_ff;
      valid_in      = valid_ff && !rsp_tready;
      high_in       = high_ff;
      low_in        = low_ff;
      bit_in        = bit_ff;
      islatch_in    = islatch_ff;
      last_in       = last_ff;
      pop           = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop           = 1'b1;
               shift_in      = head_pixel;
               left_in       = LEFT_W'(PIX_BITS - 1);
               latch_pend_in = head_flags.has_latch;
               state_in      = head_flags.has_pixel ? BK_BITS : BK_LATCH;
            end
         end
         BK_BITS: begin
            if (slot_free) begin
               valid_in   = 1'b1;
               bit_in     = cur_bit;
               high_in    = cur_bit ? one_high_ff : zero_high_ff;
               low_in     = LATCH_W'(cur_bit ? one_low_ff : zero_low_ff);
               islatch_in = 1'b0;
               last_in    = (left_ff == '0) && !latch_pend_ff;
               shift_in   = {shift_ff[PIX_BITS-2:0], 1'b0};
               left_in    = left_ff - LEFT_W'(1);
               if (left_ff == '0) begin
                  state_in = latch_pend_ff ? BK_LATCH : BK_IDLE;
               end
            end
         end
         BK_LATCH: begin
            if (slot_free) begin
               valid_in   = 1'b1;
               bit_in     = 1'b0;
               high_in    = '0;
               low_in     = latch_ff;
               islatch_in = 1'b1;
               last_in    = 1'b1;
               state_in   = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      left_ff       <= left_in;
      latch_pend_ff <= latch_pend_in;
      high_ff       <= high_in;
      low_ff        <= low_in;
      bit_ff        <= bit_in;
      islatch_ff    <= islatch_in;
      last_ff       <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZERO_HIGH_RST;
         zero_low_ff  <= ZERO_LOW_RST;
         one_high_ff  <= ONE_HIGH_RST;
         one_low_ff   <= ONE_LOW_RST;
         latch_ff     <= LATCH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata[TIME_W-1:0];
            CSR_ZERO_LOW:  zero_low_ff  <= csr_wdata[TIME_W-1:0];
            CSR_ONE_HIGH:  one_high_ff  <= csr_wdata[TIME_W-1:0];
            CSR_ONE_LOW:   one_low_ff   <= csr_wdata[TIME_W-1:0];
            CSR_LATCH:     latch_ff     <= csr_wdata[LATCH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_high   = high_ff;
   assign rsp_low    = low_ff;
   assign rsp_bit    = bit_ff;
   assign rsp_latch  = islatch_ff;
   assign rsp_last   = last_ff;

endmodule

[design/addressable_led_pulse_encoder_unit.sv]
// Top level of the addressable LED pulse encoder.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: data_byte; tlast: last_byte
//  rsp     | out | rsp_tvalid/tready    | tdata: high_time, low_time, bit_value;
//          |     |                      | tuser: is_latch; tlast: end_of_run
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// A byte that does not finish a pixel is taken whenever the job queue is not full.
// A finished pixel leaves the sequencer as one beat per bit (24 at three bytes
// a pixel), then a latch beat at packet end; the sequencer sets the rate.
// A two-entry job queue lets the front keep taking bytes while pulses go out.
// Reset is synchronous; no clearing pass.
// rsp stalls hold the output beat; req_tready drops only when the queue is full.
`timescale 1ns / 1ps
module addressable_led_pulse_encoder_unit #(
   parameter int BYTES_PER_PIXEL = alpf_pkg::BYTES_PER_PIXEL_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [alpf_pkg::BITS_PER_BYTE-1:0] req_tdata,  // data_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [alpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // high_time, low_time, bit_value
   output logic                               rsp_tuser,  // is_latch
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [alpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [alpf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import alpf_pkg::*;

   localparam int PIX_BITS = BYTES_PER_PIXEL * BITS_PER_BYTE;
   localparam int PAD_W    = RSP_DATA_W - TIME_W - LATCH_W - 1;

   logic                push;
   logic [PIX_BITS-1:0] push_pixel;
   job_flags_type       push_flags;
   logic                q_full, q_empty, pop;
   logic [PIX_BITS-1:0] head_pixel;
   job_flags_type       head_flags;
   logic [TIME_W-1:0]   rsp_high;
   logic [LATCH_W-1:0]  rsp_low;
   logic                rsp_bit;

   alpf_front #(
      .BYTES_PER_PIXEL(BYTES_PER_PIXEL),
      .PIX_BITS       (PIX_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .q_full    (q_full),
      .push      (push),
      .push_pixel(push_pixel),
      .push_flags(push_flags)
   );

   alpf_queue #(
      .PIX_BITS(PIX_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pixel(push_pixel),
      .push_flags(push_flags),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_pixel(head_pixel),
      .head_flags(head_flags)
   );

   alpf_back #(
      .PIX_BITS(PIX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .empty     (q_empty),
      .head_pixel(head_pixel),
      .head_flags(head_flags),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_high  (rsp_high),
      .rsp_low   (rsp_low),
      .rsp_bit   (rsp_bit),
      .rsp_latch (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_bit, rsp_low, rsp_high};

endmodule

[design/alpf_checker.sv]
// Port-level checker for the pulse encoder, bound to the top level.
`timescale 1ns / 1ps
module alpf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [alpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   a_latch_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[15:0] == 16'd0 && !rsp_tdata[36])
      else $error("latch beat malformed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:37] == 3'd0)
      else $error("rsp_tdata pad bits set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

endmodule

bind addressable_led_pulse_encoder_unit alpf_checker u_alpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

[sim/alpf_pulse_checker.sv]
// Checker for the LED pulse encoder: predicts pulse descriptors and compares each rsp beat.
`timescale 1ns / 1ps
module alpf_pulse_checker #(
   parameter int BYTES_PER_PIXEL = alpf_pkg::BYTES_PER_PIXEL_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [alpf_pkg::BITS_PER_BYTE-1:0] req_tdata,   // data_byte
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [alpf_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // high_time, low_time, bit_value
   input  logic                               rsp_tuser,   // is_latch
   input  logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [alpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [alpf_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 open_count
);
   import alpf_pkg::*;

   localparam int LOW_LSB = TIME_W;
   localparam int BIT_POS = TIME_W + LATCH_W;

   typedef struct packed {
      logic [TIME_W-1:0]  high_time;
      logic [LATCH_W-1:0] low_time;
      logic               bit_value;
      logic               is_latch;
      logic               end_of_run;
   } pulse_type;

   pulse_type          pulse_q[$];
   logic [TIME_W-1:0]  zero_high;
   logic [TIME_W-1:0]  zero_low;
   logic [TIME_W-1:0]  one_high;
   logic [TIME_W-1:0]  one_low;
   logic [LATCH_W-1:0] latch_len;
   logic [BITS_PER_BYTE-1:0] pixel_bytes [BYTES_PER_PIXEL];
   int                 pixel_fill;

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic predict_pulses(input logic [BITS_PER_BYTE-1:0] data, input logic last);
      pulse_type p;
      logic      b;
      pixel_bytes[pixel_fill] = data;
      pixel_fill++;
      if (pixel_fill == BYTES_PER_PIXEL) begin
         for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            for (int s = BITS_PER_BYTE - 1; s >= 0; s--) begin
               b = pixel_bytes[i][s];
               p.high_time  = b ? one_high : zero_high;
               p.low_time   = b ? LATCH_W'(one_low) : LATCH_W'(zero_low);
               p.bit_value  = b;
               p.is_latch   = 1'b0;
               p.end_of_run = !last && (i == BYTES_PER_PIXEL - 1) && (s == 0);
               pulse_q.push_back(p);
            end
         end
         pixel_fill = 0;
      end
      if (last) begin
         // drop any partial pixel, then the latch
         pixel_fill   = 0;
         p.high_time  = '0;
         p.low_time   = latch_len;
         p.bit_value  = 1'b0;
         p.is_latch   = 1'b1;
         p.end_of_run = 1'b1;
         pulse_q.push_back(p);
      end
   endtask

   task automatic check_pulse();
      pulse_type want;
      logic [TIME_W-1:0]  got_high;
      logic [LATCH_W-1:0] got_low;
      logic               got_bit;
      got_high = rsp_tdata[TIME_W-1:0];
      got_low  = rsp_tdata[LOW_LSB +: LATCH_W];
      got_bit  = rsp_tdata[BIT_POS];
      if (pulse_q.size() == 0) begin
         report("beat with nothing pending, low_time", got_low, 0);
      end else begin
         want = pulse_q.pop_front();
         if (got_high !== want.high_time) report("high_time", got_high, want.high_time);
         if (got_low !== want.low_time) report("low_time", got_low, want.low_time);
         if (got_bit !== want.bit_value) report("bit_value", got_bit, want.bit_value);
         if (rsp_tuser !== want.is_latch) report("is_latch", rsp_tuser, want.is_latch);
         if (rsp_tlast !== want.end_of_run) report("end_of_run", rsp_tlast, want.end_of_run);
         if (rsp_tdata[RSP_DATA_W-1:BIT_POS+1] !== '0)
            report("tdata padding", rsp_tdata[RSP_DATA_W-1:BIT_POS+1], 0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         zero_high  = ZERO_HIGH_RST;
         zero_low   = ZERO_LOW_RST;
         one_high   = ONE_HIGH_RST;
         one_low    = ONE_LOW_RST;
         latch_len  = LATCH_RST;
         pixel_fill = 0;
         fail_count = 0;
         pulse_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ZERO_HIGH: zero_high = csr_wdata[TIME_W-1:0];
               CSR_ZERO_LOW:  zero_low  = csr_wdata[TIME_W-1:0];
               CSR_ONE_HIGH:  one_high  = csr_wdata[TIME_W-1:0];
               CSR_ONE_LOW:   one_low   = csr_wdata[TIME_W-1:0];
               CSR_LATCH:     latch_len = csr_wdata[LATCH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_pulses(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_pulse();
      end
      open_count <= pulse_q.size();
   end

endmodule

[sim/tb_top.sv]
// Testbench top for the LED pulse encoder: reset, register settings, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import alpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 26;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [BITS_PER_BYTE-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index  = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata  = '0;
   wire                      req_tready;
   wire                      rsp_tvalid;
   wire  [RSP_DATA_W-1:0]    rsp_tdata;
   wire                      rsp_tuser;
   wire                      rsp_tlast;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_req       = 1'b0;
   logic hold_ack       = 1'b0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;
   int   bytes_sent     = 0;
   int   fail_count;
   int   open_count;

   always #1 clock = ~clock;

   addressable_led_pulse_encoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // data_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // high_time, low_time, bit_value
      .rsp_tuser  (rsp_tuser),   // is_latch
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   alpf_pulse_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_ack   <= hold_req;
      end else if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BITS_PER_BYTE-1:0] data, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   function automatic logic [BITS_PER_BYTE-1:0] pick_byte();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return BITS_PER_BYTE'($urandom);
      endcase
   endfunction

   // mostly whole pixels; some packets of one to eight bytes to hit the trim
   task automatic send_packet();
      int len;
      if ($urandom_range(9) < 7) len = 3 * $urandom_range(1, 3);
      else len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
   endtask

   task automatic drain();
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int target);
      bytes_sent = 0;
      while (bytes_sent < target) send_packet();
      req_tvalid <= 1'b0;
      drain();
   endtask

   task automatic write_regs(input logic [TIME_W-1:0] zh, input logic [TIME_W-1:0] zl,
                             input logic [TIME_W-1:0] oh, input logic [TIME_W-1:0] ol,
                             input logic [LATCH_W-1:0] lt);
      logic [CSR_DATA_W-1:0] vals [2**CSR_IDX_W];
      for (int i = 0; i < 2**CSR_IDX_W; i++) vals[i] = CSR_DATA_W'($urandom);
      // upper bits of the narrow registers stay random to exercise the mask
      vals[CSR_ZERO_HIGH][TIME_W-1:0] = zh;
      vals[CSR_ZERO_LOW][TIME_W-1:0]  = zl;
      vals[CSR_ONE_HIGH][TIME_W-1:0]  = oh;
      vals[CSR_ONE_LOW][TIME_W-1:0]   = ol;
      vals[CSR_LATCH][LATCH_W-1:0]    = lt;
      for (int i = 0; i < 2**CSR_IDX_W; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: whole pixels, a pixel closed by the last beat,
      // a lone last beat, partial pixels dropped at packet end
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      req_tvalid <= 1'b0;
      drain();

      write_regs('0, '0, '0, '0, '0);
      run_phase(PHASE_ITEMS);

      write_regs('1, '1, '1, '1, '1);
      send_idle_pct <= 46;
      run_phase(PHASE_ITEMS);

      write_regs(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                 TIME_W'($urandom), LATCH_W'($urandom));
      send_idle_pct  <= 0;
      recv_stall_pct <= 46;
      hold_req       <= ~hold_req;
      run_phase(PHASE_ITEMS);

      write_regs(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                 TIME_W'($urandom), LATCH_W'($urandom));
      send_idle_pct  <= 32;
      recv_stall_pct <= 32;
      run_phase(PHASE_ITEMS);

      if (fail_count == 0 && open_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
design/alpf_pkg.sv
design/alpf_front.sv
design/alpf_queue.sv
design/alpf_back.sv
design/addressable_led_pulse_encoder_unit.sv
design/alpf_checker.sv
sim/alpf_pulse_checker.sv
sim/tb_top.sv
